### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("property violated");

// condition must never be seen outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

### src/qrm_pkg.sv
package qrm_pkg;

  // field widths
  localparam int unsigned QuatW  = 16;
  localparam int unsigned ProdW  = 32;
  localparam int unsigned AccW   = 36;
  localparam int unsigned EntryW = 18;
  localparam int unsigned FracW  = 15;

  typedef logic signed [QuatW-1:0]  quat_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [AccW-1:0]   acc_t;
  typedef logic signed [EntryW-1:0] entry_t;

  // one in the product scale and half an output lsb
  localparam acc_t OneQ30  = acc_t'(64'sd1 <<< 30);
  localparam acc_t HalfLsb = acc_t'(64'sd1 <<< 14);

  // saturation limits of the output format
  localparam entry_t EntryMax = entry_t'(131071);
  localparam entry_t EntryMin = entry_t'(-131072);
  localparam entry_t EntryOne = entry_t'(32768);

  // round half up, drop the fraction, saturate to the output format
  function automatic entry_t round_sat(acc_t v);
    acc_t r;
    r = (v + HalfLsb) >>> FracW;
    if (r > acc_t'(EntryMax)) begin
      round_sat = EntryMax;
    end else if (r < acc_t'(EntryMin)) begin
      round_sat = EntryMin;
    end else begin
      round_sat = r[EntryW-1:0];
    end
  endfunction

endpackage

### src/quaternion_to_rotation_matrix.sv
// Quaternion to rotation matrix, fixed point.
// Input channel: a quaternion beat (quat_w_i, quat_x_i, quat_y_i, quat_z_i,
// signed Q1.15) is taken at every rising edge where start is high and busy
// is low. busy stays low, so one beat can enter in every cycle.
// Output channel: the nine matrix entries m_rXcY_o (signed Q3.15, rounded
// half up and saturated) appear together with done_o for exactly one cycle.
// A beat passes in turn through the product, sum and output registers and is
// then shown with done_o. Throughput: one beat per cycle,
// set by the three register stages (nine 16x16 multiplies, then the sums,
// then rounding and saturation), each of which takes a new beat every cycle.
// Reset clears the valid bits of all stages, so beats in flight are dropped
// and done_o stays low until a new beat has passed through. The receiver
// cannot stall: each result is shown once and is gone in the next cycle.
module quaternion_to_rotation_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  qrm_pkg::quat_t quat_w_i,
  input  qrm_pkg::quat_t quat_x_i,
  input  qrm_pkg::quat_t quat_y_i,
  input  qrm_pkg::quat_t quat_z_i,
  output logic           done_o,
  output qrm_pkg::entry_t m_r0c0_o,
  output qrm_pkg::entry_t m_r0c1_o,
  output qrm_pkg::entry_t m_r0c2_o,
  output qrm_pkg::entry_t m_r1c0_o,
  output qrm_pkg::entry_t m_r1c1_o,
  output qrm_pkg::entry_t m_r1c2_o,
  output qrm_pkg::entry_t m_r2c0_o,
  output qrm_pkg::entry_t m_r2c1_o,
  output qrm_pkg::entry_t m_r2c2_o
);
  import qrm_pkg::*;

  logic   s1_vld_q, s2_vld_q, s3_vld_q;
  prod_t  xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
  acc_t   a00_q, a01_q, a02_q, a10_q, a11_q, a12_q, a20_q, a21_q, a22_q;
  acc_t   a00_d, a01_d, a02_d, a10_d, a11_d, a12_d, a20_d, a21_d, a22_d;
  entry_t m00_q, m01_q, m02_q, m10_q, m11_q, m12_q, m20_q, m21_q, m22_q;
  logic   accept;

  // the pipeline never holds off a beat
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // stage 1: nine exact Q2.30 products
  always_ff @(posedge clk_i) begin
    xx_q <= prod_t'(quat_x_i) * prod_t'(quat_x_i);
    yy_q <= prod_t'(quat_y_i) * prod_t'(quat_y_i);
    zz_q <= prod_t'(quat_z_i) * prod_t'(quat_z_i);
    xy_q <= prod_t'(quat_x_i) * prod_t'(quat_y_i);
    xz_q <= prod_t'(quat_x_i) * prod_t'(quat_z_i);
    yz_q <= prod_t'(quat_y_i) * prod_t'(quat_z_i);
    xw_q <= prod_t'(quat_x_i) * prod_t'(quat_w_i);
    yw_q <= prod_t'(quat_y_i) * prod_t'(quat_w_i);
    zw_q <= prod_t'(quat_z_i) * prod_t'(quat_w_i);
  end

  // stage 2: exact entries in Q2.30 scale
  always_comb begin
    a00_d = OneQ30 - ((acc_t'(yy_q) + acc_t'(zz_q)) <<< 1);
    a11_d = OneQ30 - ((acc_t'(xx_q) + acc_t'(zz_q)) <<< 1);
    a22_d = OneQ30 - ((acc_t'(xx_q) + acc_t'(yy_q)) <<< 1);
    a01_d = (acc_t'(xy_q) - acc_t'(zw_q)) <<< 1;
    a10_d = (acc_t'(xy_q) + acc_t'(zw_q)) <<< 1;
    a02_d = (acc_t'(xz_q) + acc_t'(yw_q)) <<< 1;
    a20_d = (acc_t'(xz_q) - acc_t'(yw_q)) <<< 1;
    a12_d = (acc_t'(yz_q) - acc_t'(xw_q)) <<< 1;
    a21_d = (acc_t'(yz_q) + acc_t'(xw_q)) <<< 1;
  end

  always_ff @(posedge clk_i) begin
    a00_q <= a00_d;
    a01_q <= a01_d;
    a02_q <= a02_d;
    a10_q <= a10_d;
    a11_q <= a11_d;
    a12_q <= a12_d;
    a20_q <= a20_d;
    a21_q <= a21_d;
    a22_q <= a22_d;
  end

  // stage 3: round to Q3.15 and saturate into the output register
  always_ff @(posedge clk_i) begin
    m00_q <= round_sat(a00_q);
    m01_q <= round_sat(a01_q);
    m02_q <= round_sat(a02_q);
    m10_q <= round_sat(a10_q);
    m11_q <= round_sat(a11_q);
    m12_q <= round_sat(a12_q);
    m20_q <= round_sat(a20_q);
    m21_q <= round_sat(a21_q);
    m22_q <= round_sat(a22_q);
  end

  assign done_o   = s3_vld_q;
  assign m_r0c0_o = m00_q;
  assign m_r0c1_o = m01_q;
  assign m_r0c2_o = m02_q;
  assign m_r1c0_o = m10_q;
  assign m_r1c1_o = m11_q;
  assign m_r1c2_o = m12_q;
  assign m_r2c0_o = m20_q;
  assign m_r2c1_o = m21_q;
  assign m_r2c2_o = m22_q;

endmodule

### src/qrm_checker.sv
`include "assert_macros.svh"

module qrm_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input qrm_pkg::quat_t  quat_w_i,
  input qrm_pkg::quat_t  quat_x_i,
  input qrm_pkg::quat_t  quat_y_i,
  input qrm_pkg::quat_t  quat_z_i,
  input logic            done_o,
  input qrm_pkg::entry_t m_r0c0_o,
  input qrm_pkg::entry_t m_r1c1_o,
  input qrm_pkg::entry_t m_r2c2_o,
  input qrm_pkg::entry_t m_r0c1_o
);
  import qrm_pkg::*;

  logic accept, zero_in, ident_out;

  assign accept    = start && !busy;
  assign zero_in   = accept && quat_w_i == '0 && quat_x_i == '0
                     && quat_y_i == '0 && quat_z_i == '0;
  assign ident_out = m_r0c0_o == EntryOne && m_r1c1_o == EntryOne
                     && m_r2c2_o == EntryOne && m_r0c1_o == '0;

  // a pipelined block never holds off a beat
  `ASSERT_NEVER(busy_never, clk_i, rst_ni, busy)
  // every accepted beat comes out with done_o
  `ASSERT_PROP(beat_out, clk_i, rst_ni, accept |-> ##3 done_o)
  // no result without an accepted beat before it
  `ASSERT_PROP(no_phantom, clk_i, rst_ni, done_o |-> $past(accept, 3))
  // the zero quaternion gives ones on the diagonal
  `ASSERT_PROP(zero_diag, clk_i, rst_ni, zero_in |-> ##3 ident_out)

endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .quat_w_i (quat_w_i),
  .quat_x_i (quat_x_i),
  .quat_y_i (quat_y_i),
  .quat_z_i (quat_z_i),
  .done_o   (done_o),
  .m_r0c0_o (m_r0c0_o),
  .m_r1c1_o (m_r1c1_o),
  .m_r2c2_o (m_r2c2_o),
  .m_r0c1_o (m_r0c1_o)
);
